FILE: hw/rtl/sxpk_pkg.sv
// Shared types and constants for the seven-bit SysEx packetizer.
`default_nettype none

package sxpk_pkg;

   // One raw payload byte of an outgoing message, or an empty-payload marker.
   typedef struct packed {
      logic [6:0] command;
      logic [7:0] data_byte;
      logic       final_byte;
      logic       no_payload;
   } req_payload_type;

   // One USB-MIDI event packet.
   typedef struct packed {
      logic [7:0] packet_header;
      logic [7:0] packet_byte_a;
      logic [7:0] packet_byte_b;
      logic [7:0] packet_byte_c;
      logic       message_end;
      logic       run_last;
   } rsp_payload_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_CABLE_NUMBER = 2'd0,
      CSR_ID_FIRST     = 2'd1,
      CSR_ID_SECOND    = 2'd2,
      CSR_ID_THIRD     = 2'd3
   } csr_index_type;

   localparam logic [3:0] CABLE_NUMBER_RESET = 4'd0;
   localparam logic [6:0] ID_FIRST_RESET     = 7'd125;
   localparam logic [6:0] ID_SECOND_RESET    = 7'd66;
   localparam logic [6:0] ID_THIRD_RESET     = 7'd77;

   localparam logic [7:0] SYX_START = 8'hF0;
   localparam logic [7:0] SYX_END   = 8'hF7;
   localparam logic [7:0] HIGH_BIT  = 8'h80;
   localparam logic [7:0] LOW_BITS  = 8'h7F;

   // Code index numbers of the packet header.
   localparam logic [3:0] CIN_SYX_CONT   = 4'h4;
   localparam logic [3:0] CIN_SYX_END_1  = 4'h5;
   localparam logic [3:0] CIN_SYX_END_2  = 4'h6;
   localparam logic [3:0] CIN_SYX_END_3  = 4'h7;

endpackage

`default_nettype wire

FILE: hw/rtl/sysex_seven_bit_packetizer_core.sv
// Seven-bit SysEx packetizer: raw message bytes in, USB-MIDI event packets out.
`default_nettype none

// This block turns the raw payload bytes of an outgoing message into USB-MIDI
// SysEx event packets. The first item of a message opens the body with F0, the
// three ID bytes and the command; payload bytes are gathered in groups of up to
// seven and sent as a leading byte of their high bits followed by the bytes with
// bit 7 cleared; the item that carries final_byte or no_payload flushes the open
// group and closes the body with F7. Body bytes are packed three to a packet.
// An item is accepted and fully worked out in the same cycle: its packets are
// loaded into a burst register and the leftover body bytes stay in the pending
// state. Packets appear in the cycle after the item is accepted and leave at one
// packet per cycle while rsp_ready is high. An item that makes k packets (at
// most four) holds the input until the burst register has drained them; the
// register takes the next item in the cycle its last packet is taken.
// Configuration registers are always ready and should only be written while
// no message is in flight.
module sysex_seven_bit_packetizer_core (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire sxpk_pkg::req_payload_type req_payload,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output sxpk_pkg::rsp_payload_type  rsp_payload,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire sxpk_pkg::csr_index_type   csr_index,
   input  wire  [6:0]                 csr_wdata
);
   import sxpk_pkg::*;

   // Configuration registers.
   logic [3:0] cable_ff;
   logic [6:0] id_first_ff;
   logic [6:0] id_second_ff;
   logic [6:0] id_third_ff;

   // Message state.
   logic       in_msg_ff, in_msg_in;
   logic [2:0] group_fill_ff, group_fill_in;
   logic [7:0] store_ff [7];
   logic [7:0] pend_ff [2];
   logic [7:0] pend_in [2];
   logic [1:0] pend_fill_ff, pend_fill_in;

   // Burst register: up to four packets of three bytes each.
   logic [7:0] burst_ff [12];
   logic [7:0] burst_in [12];
   logic [2:0] pkt_cnt_ff, pkt_cnt_in;
   logic       burst_end_ff, burst_end_in;
   logic [3:0] end_cin_ff, end_cin_in;

   logic       req_fire;
   logic       rsp_fire;

   // Single pass logic.
   logic       is_end;
   logic       flush;
   logic [2:0] eff_fill;
   logic [3:0] grp_cnt;
   logic [3:0] grp_len;
   logic [2:0] pref_len;
   logic [3:0] total_len;
   logic [1:0] full_pkts;
   logic [3:0] rem_wide;
   logic [1:0] rem;
   logic [7:0] pref [12];
   logic [7:0] grp_entry [7];
   logic [7:0] grp_byte [8];
   logic [7:0] lead;
   logic [7:0] sbuf [12];

   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;
   assign rsp_valid = (pkt_cnt_ff != 3'd0);
   // The burst register takes a new item once it is empty or its last packet leaves.
   assign req_ready = (pkt_cnt_ff == 3'd0) || ((pkt_cnt_ff == 3'd1) && rsp_ready);
   assign csr_ready = 1'b1;

   // The item that ends the message: a final byte, or a message with no payload.
   assign is_end   = req_payload.no_payload || req_payload.final_byte;
   // A new message starts with an empty group.
   assign eff_fill = in_msg_ff ? group_fill_ff : 3'd0;
   assign grp_cnt  = {1'b0, eff_fill} + {3'd0, !req_payload.no_payload};
   assign flush    = is_end || (grp_cnt == 4'd7);
   assign grp_len  = (flush && (grp_cnt != 4'd0)) ? 4'(grp_cnt + 4'd1) : 4'd0;
   assign pref_len = in_msg_ff ? {1'b0, pend_fill_ff} : 3'd5;
   assign total_len = 4'({1'b0, pref_len} + grp_len + {3'd0, is_end});

   // Group entries as they stand after this item's byte is added.
   always_comb begin
      lead = 8'd0;
      for (int k = 0; k < 7; k++) begin
         if (!req_payload.no_payload && (eff_fill == 3'(k))) begin
            grp_entry[k] = req_payload.data_byte;
         end else begin
            grp_entry[k] = store_ff[k];
         end
         if ((4'(k) < grp_cnt) && ((grp_entry[k] & HIGH_BIT) != 8'd0)) begin
            lead[k] = 1'b1;
         end
         grp_byte[k + 1] = grp_entry[k] & LOW_BITS;
      end
      grp_byte[0] = lead;
   end

   // Bytes that precede the group: the message header, or the pending bytes.
   always_comb begin
      for (int i = 0; i < 12; i++) begin
         pref[i] = 8'd0;
      end
      if (in_msg_ff) begin
         pref[0] = pend_ff[0];
         pref[1] = pend_ff[1];
      end else begin
         pref[0] = SYX_START;
         pref[1] = {1'b0, id_first_ff};
         pref[2] = {1'b0, id_second_ff};
         pref[3] = {1'b0, id_third_ff};
         pref[4] = {1'b0, req_payload.command};
      end
   end

   // Body stream of this item: prefix, then the flushed group, then F7.
   always_comb begin
      logic [3:0] pos;
      logic [3:0] gpos;
      for (int i = 0; i < 12; i++) begin
         pos  = 4'(i);
         gpos = 4'(pos - {1'b0, pref_len});
         if (pos < {1'b0, pref_len}) begin
            sbuf[i] = pref[i];
         end else if (gpos < grp_len) begin
            sbuf[i] = grp_byte[gpos[2:0]];
         end else if (is_end && (gpos == grp_len)) begin
            sbuf[i] = SYX_END;
         end else begin
            sbuf[i] = 8'd0;
         end
      end
   end

   // Full packets in the stream; the stream is never longer than eleven bytes.
   always_comb begin
      case (total_len)
         4'd0, 4'd1, 4'd2:   full_pkts = 2'd0;
         4'd3, 4'd4, 4'd5:   full_pkts = 2'd1;
         4'd6, 4'd7, 4'd8:   full_pkts = 2'd2;
         default:            full_pkts = 2'd3;
      endcase
      rem_wide = 4'(total_len - 4'(3 * full_pkts));
      rem      = rem_wide[1:0];
   end

   // Next state of the message and the burst to send.
   always_comb begin
      in_msg_in     = in_msg_ff;
      group_fill_in = group_fill_ff;
      pend_fill_in  = pend_fill_ff;
      pend_in[0]    = pend_ff[0];
      pend_in[1]    = pend_ff[1];
      pkt_cnt_in    = pkt_cnt_ff;
      burst_end_in  = burst_end_ff;
      end_cin_in    = end_cin_ff;
      for (int i = 0; i < 12; i++) begin
         burst_in[i] = burst_ff[i];
      end

      // The burst moves up by one packet only when its head packet is taken.
      if (rsp_fire) begin
         pkt_cnt_in = 3'(pkt_cnt_ff - 3'd1);
         for (int i = 0; i < 9; i++) begin
            burst_in[i] = burst_ff[i + 3];
         end
         for (int i = 9; i < 12; i++) begin
            burst_in[i] = 8'd0;
         end
      end

      if (req_fire) begin
         in_msg_in     = !is_end;
         group_fill_in = flush ? 3'd0 : grp_cnt[2:0];
         for (int i = 0; i < 12; i++) begin
            burst_in[i] = sbuf[i];
         end
         burst_end_in = is_end;
         if (is_end) begin
            // The closing packet holds the leftover bytes and F7.
            pend_fill_in = 2'd0;
            pkt_cnt_in   = (rem != 2'd0) ? 3'({1'b0, full_pkts} + 3'd1) : {1'b0, full_pkts};
            case (rem)
               2'd1:    end_cin_in = CIN_SYX_END_1;
               2'd2:    end_cin_in = CIN_SYX_END_2;
               default: end_cin_in = CIN_SYX_END_3;
            endcase
         end else begin
            pend_fill_in = rem;
            pkt_cnt_in   = {1'b0, full_pkts};
            case (full_pkts)
               2'd0: begin
                  pend_in[0] = sbuf[0];
                  pend_in[1] = sbuf[1];
               end
               2'd1: begin
                  pend_in[0] = sbuf[3];
                  pend_in[1] = sbuf[4];
               end
               2'd2: begin
                  pend_in[0] = sbuf[6];
                  pend_in[1] = sbuf[7];
               end
               default: begin
                  pend_in[0] = sbuf[9];
                  pend_in[1] = sbuf[10];
               end
            endcase
         end
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff     <= 1'b0;
         group_fill_ff <= 3'd0;
         pend_fill_ff  <= 2'd0;
         pkt_cnt_ff    <= 3'd0;
         burst_end_ff  <= 1'b0;
         cable_ff      <= CABLE_NUMBER_RESET;
         id_first_ff   <= ID_FIRST_RESET;
         id_second_ff  <= ID_SECOND_RESET;
         id_third_ff   <= ID_THIRD_RESET;
      end else begin
         in_msg_ff     <= in_msg_in;
         group_fill_ff <= group_fill_in;
         pend_fill_ff  <= pend_fill_in;
         pkt_cnt_ff    <= pkt_cnt_in;
         burst_end_ff  <= burst_end_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CABLE_NUMBER: cable_ff     <= csr_wdata[3:0];
               CSR_ID_FIRST:     id_first_ff  <= csr_wdata;
               CSR_ID_SECOND:    id_second_ff <= csr_wdata;
               CSR_ID_THIRD:     id_third_ff  <= csr_wdata;
               default:          ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      end_cin_ff <= end_cin_in;
      pend_ff[0] <= pend_in[0];
      pend_ff[1] <= pend_in[1];
      for (int i = 0; i < 12; i++) begin
         burst_ff[i] <= burst_in[i];
      end
      if (req_fire && !req_payload.no_payload) begin
         store_ff[eff_fill] <= req_payload.data_byte;
      end
   end

   // The packet at the head of the burst register.
   always_comb begin
      rsp_payload.run_last      = (pkt_cnt_ff == 3'd1);
      rsp_payload.message_end   = (pkt_cnt_ff == 3'd1) && burst_end_ff;
      rsp_payload.packet_header = {cable_ff,
                                   rsp_payload.message_end ? end_cin_ff : CIN_SYX_CONT};
      rsp_payload.packet_byte_a = burst_ff[0];
      rsp_payload.packet_byte_b = burst_ff[1];
      rsp_payload.packet_byte_c = burst_ff[2];
   end

   // A new item only lands in the burst register as its last packet leaves.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_valid) |-> (rsp_ready && rsp_payload.run_last))
      else $error("item accepted over an undelivered burst");

   // The closing packet is always the last one of its item.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.message_end) |-> rsp_payload.run_last)
      else $error("message end packet is not the last of its burst");

   // Ending a message leaves no group, no pending bytes and no open message.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_payload.final_byte || req_payload.no_payload)) |=>
      (!in_msg_ff && (group_fill_ff == 3'd0) && (pend_fill_ff == 2'd0)))
      else $error("message state not cleared after its end");

   // A full group is always flushed in the same pass, and the burst never holds more than four packets.
   assert property (@(posedge clock) disable iff (reset)
      (group_fill_ff != 3'd7) && (pkt_cnt_ff <= 3'd4))
      else $error("group fill or burst count out of range");

endmodule

`default_nettype wire
